### rtl/core/ffcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffcs_pkg
// shared types, constants and the crc-8 byte update for the flow frame
// check and scale block
// ----------------------------------------------------------------------------
package ffcs_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int DIFF_W     = WORD_W + 1;
   localparam int FLOW_W     = 25;
   localparam int STATUS_W   = 2;
   localparam int QUO_W      = WORD_W + BYTE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_CRC   = 2'd1,
      STATUS_SCALE = 2'd2
   } status_type;

   typedef struct packed {
      status_type                status;
      logic signed [DIFF_W-1:0]  diff;
      logic signed [WORD_W-1:0]  scale;
   } job_type;

   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/core/ffcs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffcs_if
// valid/ready channels for frame bytes in and flow results out
// ----------------------------------------------------------------------------
interface ffcs_req_if;
   logic                          valid;
   logic                          ready;
   logic [ffcs_pkg::BYTE_W-1:0]   rx_byte;
   logic                          frame_start;

   modport source(output valid, output rx_byte, output frame_start, input ready);
   modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

interface ffcs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ffcs_pkg::FLOW_W-1:0]   flow_q8;
   logic [ffcs_pkg::STATUS_W-1:0]        status;

   modport source(output valid, output flow_q8, output status, input ready);
   modport sink(input valid, input flow_q8, input status, output ready);
endinterface
`default_nettype wire

### rtl/core/flow_frame_check_and_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flow_frame_check_and_scale
// checks the crc of the flow word in a sensor frame and gives
// (raw - offset) * 256 / scale in signed q8 with a status
//
//   channel  dir  words                      handshake
//   req_ch   in   rx_byte, frame_start       valid/ready
//   rsp_ch   out  flow_q8, status            valid/ready
//   csr_*    in   csr_index, csr_wdata       csr_we, no wait
//
// one byte a cycle is taken while the two-entry job queue has room
// a good flow word passes the job queue, a load step, the 24-step serial
// divider and a sign step before it is valid in the result register; an error
// word goes from the load step straight to the result register
// a stalled result holds the divider; the queue then fills and drops req ready
// synchronous reset: position 0, crc 0xff, config to defaults, queue empty
// ----------------------------------------------------------------------------
module flow_frame_check_and_scale #(
   parameter int FRAME_BYTES = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   ffcs_req_if.sink                          req_ch,
   ffcs_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [ffcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ffcs_pkg::*;

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   job_type   push_job;
   job_type   pop_job;

   ffcs_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   ffcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   ffcs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_job   (pop_job),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire

### rtl/core/ffcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffcs_front
// takes frame bytes, tracks position, raw flow word and crc, holds the
// config registers and queues one division job per checked flow word while enabled
// ----------------------------------------------------------------------------
module ffcs_front #(
   parameter int FRAME_BYTES = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   ffcs_req_if.sink                          req_ch,
   input  logic                              csr_we,
   input  logic [ffcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffcs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              q_full,
   output logic                              q_push,
   output ffcs_pkg::job_type                 q_job
);
   import ffcs_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_HI  = '0;
   localparam logic [POS_W-1:0] POS_LO  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_CRC = POS_W'(2);
   localparam logic [POS_W:0]   POS_END = (POS_W+1)'(FRAME_BYTES);

   logic                      enabled_ff, enabled_in;
   logic signed [WORD_W-1:0]  offset_ff, offset_in;
   logic signed [WORD_W-1:0]  scale_ff, scale_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [BYTE_W-1:0]         crc_ff, crc_in;
   logic [WORD_W-1:0]         word_ff, word_in;

   logic                      accept;
   logic [POS_W-1:0]          pos_cur;
   logic [BYTE_W-1:0]         crc_cur;
   logic [BYTE_W-1:0]         crc_upd;
   logic [POS_W:0]            pos_next;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_cur  = req_ch.frame_start ? POS_HI : pos_ff;
   assign crc_cur  = req_ch.frame_start ? CRC_INIT : crc_ff;
   assign crc_upd  = crc8_byte(crc_cur, req_ch.rx_byte);
   assign pos_next = {1'b0, pos_cur} + (POS_W+1)'(1);

   // config registers
   always_comb begin
      enabled_in = enabled_ff;
      offset_in  = offset_ff;
      scale_in   = scale_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLED: enabled_in = csr_wdata[0];
            CSR_OFFSET:  offset_in  = csr_wdata[WORD_W-1:0];
            CSR_SCALE:   scale_in   = csr_wdata[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   // byte tracking and job build
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      word_in      = word_ff;
      q_push       = 1'b0;
      q_job.status = STATUS_OK;
      q_job.diff   = $signed({word_ff[WORD_W-1], word_ff})
                   - $signed({offset_ff[WORD_W-1], offset_ff});
      q_job.scale  = scale_ff;
      if (req_ch.rx_byte != crc_cur) begin
         q_job.status = STATUS_CRC;
      end else if (scale_ff == '0) begin
         q_job.status = STATUS_SCALE;
      end
      if (accept) begin
         crc_in = crc_cur;
         unique case (pos_cur)
            POS_HI: begin
               word_in = {{(WORD_W-BYTE_W){1'b0}}, req_ch.rx_byte};
               crc_in  = crc_upd;
            end
            POS_LO: begin
               word_in = {word_ff[BYTE_W-1:0], req_ch.rx_byte};
               crc_in  = crc_upd;
            end
            POS_CRC: q_push = enabled_ff;
            default: ;
         endcase
         if (pos_next >= POS_END) begin
            pos_in = POS_HI;
            crc_in = CRC_INIT;
         end else begin
            pos_in = pos_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         offset_ff  <= '0;
         scale_ff   <= WORD_W'(1);
         pos_ff     <= POS_HI;
         crc_ff     <= CRC_INIT;
         word_ff    <= '0;
      end else begin
         enabled_ff <= enabled_in;
         offset_ff  <= offset_in;
         scale_ff   <= scale_in;
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         word_ff    <= word_in;
      end
   end

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < POS_END)
      else $error("byte position past frame end");

endmodule
`default_nettype wire

### rtl/core/ffcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffcs_queue
// short job fifo between the byte front end and the divider
// ----------------------------------------------------------------------------
module ffcs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ffcs_pkg::job_type   push_job,
   input  logic                pop,
   output ffcs_pkg::job_type   pop_job,
   output logic                full,
   output logic                empty
);
   import ffcs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = count_ff == CNT_FULL;
   assign empty   = count_ff == '0;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("job pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from empty queue");

endmodule
`default_nettype wire

### rtl/core/ffcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffcs_back
// serial signed divider: (diff * 256) / scale, truncated toward zero,
// one quotient bit per cycle, result held in an output register
// ----------------------------------------------------------------------------
module ffcs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  ffcs_pkg::job_type   q_job,
   output logic                q_pop,
   ffcs_rsp_if.source          rsp_ch
);
   import ffcs_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SIGN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [WORD_W-1:0]         rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [WORD_W-1:0]         dvs_ff, dvs_in;
   logic                      neg_ff, neg_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [FLOW_W-1:0]  flow_ff, flow_in;
   status_type                status_ff, status_in;

   logic [DIFF_W-1:0]         diff_mag;
   logic [WORD_W-1:0]         scale_mag;
   logic [WORD_W:0]           trial;
   logic [WORD_W:0]           trial_sub;
   logic                      take;
   logic [FLOW_W-1:0]         quo_ext;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   assign diff_mag  = q_job.diff[DIFF_W-1] ? DIFF_W'(-q_job.diff) : DIFF_W'(q_job.diff);
   assign scale_mag = q_job.scale[WORD_W-1] ? WORD_W'(-q_job.scale) : WORD_W'(q_job.scale);
   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign take      = trial >= {1'b0, dvs_ff};
   assign quo_ext   = {{(FLOW_W-QUO_W){1'b0}}, quo_ff};

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      flow_in   = flow_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               status_in = q_job.status;
               flow_in   = '0;
               rem_in    = '0;
               quo_in    = {diff_mag[WORD_W-1:0], {BYTE_W{1'b0}}};
               dvs_in    = scale_mag;
               neg_in    = q_job.diff[DIFF_W-1] ^ q_job.scale[WORD_W-1];
               cnt_in    = CNT_LAST;
               state_in  = (q_job.status == STATUS_OK) ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            rem_in = take ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], take};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            flow_in  = neg_ff ? $signed(-quo_ext) : $signed(quo_ext);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      flow_ff   <= flow_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_ch.valid   = state_ff == ST_DONE;
   assign rsp_ch.flow_q8 = flow_ff;
   assign rsp_ch.status  = status_ff;

   a_error_zero_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status != STATUS_OK) |-> rsp_ch.flow_q8 == '0)
      else $error("error word with nonzero flow");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(flow_ff)
                                        && $stable(status_ff))
      else $error("result word changed while stalled");

endmodule
`default_nettype wire

### tb/ffcs_tb_pkg.sv
// ----------------------------------------------------------------------------
// ffcs_tb_pkg
// crc-8 byte update shared by the frame builder and the flow checker
// ----------------------------------------------------------------------------
package ffcs_tb_pkg;

   import ffcs_pkg::*;

   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      logic              fb;
      r = crc ^ data;
      repeat (BYTE_W) begin
         fb = r[BYTE_W-1];
         r  = r << 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

### tb/flow_scale_checker.sv
// ----------------------------------------------------------------------------
// flow_scale_checker
// watches the byte, result and register ports of the flow frame block,
// tracks frame position, crc and flow word per accepted byte, predicts the
// status and q8 flow of every crc byte taken while enabled and compares each result word in order
// ----------------------------------------------------------------------------
module flow_scale_checker #(
   parameter int FRAME_BYTES = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   ffcs_req_if                             req_ch,
   ffcs_rsp_if                             rsp_ch,
   input  logic                            csr_we,
   input  logic [ffcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import ffcs_pkg::*;
   import ffcs_tb_pkg::*;

   typedef struct packed {
      status_type                status;
      logic signed [FLOW_W-1:0]  flow_q8;
   } flow_word_type;

   flow_word_type flow_due[$];

   logic                     en_q;
   logic signed [WORD_W-1:0] offset_q;
   logic signed [WORD_W-1:0] scale_q;
   logic [3:0]               pos_q;
   logic [BYTE_W-1:0]        crc_q;
   logic [WORD_W-1:0]        raw_q;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 100) begin
         $display("%0t ns flow mismatch: %s", $time, what);
      end
   endtask

   task automatic predict_flow_byte(input logic [BYTE_W-1:0] b, input logic fs);
      flow_word_type w;
      longint        diff;
      if (fs) begin
         pos_q = '0;
         crc_q = CRC_INIT;
      end
      case (pos_q)
         4'd0: begin
            raw_q[15:8] = b;
            crc_q       = crc8_step(crc_q, b);
         end
         4'd1: begin
            raw_q[7:0] = b;
            crc_q      = crc8_step(crc_q, b);
         end
         4'd2: begin
            if (en_q) begin
               w.flow_q8 = '0;
               if (b != crc_q) begin
                  w.status = STATUS_CRC;
               end else if (scale_q == 0) begin
                  w.status = STATUS_SCALE;
               end else begin
                  diff      = longint'(signed'(raw_q)) - longint'(offset_q);
                  w.flow_q8 = FLOW_W'((diff * 256) / longint'(scale_q));
                  w.status  = STATUS_OK;
               end
               flow_due.push_back(w);
            end
         end
         default: ;
      endcase
      if (int'(pos_q) + 1 >= FRAME_BYTES) begin
         pos_q = '0;
         crc_q = CRC_INIT;
      end else begin
         pos_q = pos_q + 4'd1;
      end
   endtask

   always @(posedge clock) begin
      flow_word_type exp_w;
      if (reset) begin
         en_q     = 1'b0;
         offset_q = '0;
         scale_q  = 16'sd1;
         pos_q    = '0;
         crc_q    = CRC_INIT;
         raw_q    = '0;
         flow_due.delete();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (flow_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word flow %0d status %0d",
                                         rsp_ch.flow_q8, rsp_ch.status));
            end else begin
               exp_w = flow_due.pop_front();
               if (rsp_ch.status !== exp_w.status) begin
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_ch.status, exp_w.status));
               end
               if (rsp_ch.flow_q8 !== exp_w.flow_q8) begin
                  report_mismatch($sformatf("flow_q8 %0d, want %0d",
                                            rsp_ch.flow_q8, exp_w.flow_q8));
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLED: en_q     = csr_wdata[0];
               CSR_OFFSET:  offset_q = csr_wdata;
               CSR_SCALE:   scale_q  = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            predict_flow_byte(req_ch.rx_byte, req_ch.frame_start);
         end
      end
      pending = flow_due.size();
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives sensor frames into the flow frame block: a short directed set for
// the flow and scale extremes, both error kinds, disabled mode and a restart
// mid-frame, then random register settings with mostly well-formed frames,
// broken frames and byte noise, random gaps on both sides and long result
// holds; the checker beside the block predicts and compares every word
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import ffcs_pkg::*;
   import ffcs_tb_pkg::*;

   localparam int FRAME_LEN   = 9;
   localparam int ITEM_TARGET = 1950;
   localparam int SETTLE_CYC  = 40;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   bit                    calm;
   bit                    aligned;
   int                    sent;

   ffcs_req_if req_ch();
   ffcs_rsp_if rsp_ch();

   flow_frame_check_and_scale #(
      .FRAME_BYTES(FRAME_LEN)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   flow_scale_checker #(
      .FRAME_BYTES(FRAME_LEN)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: random stall after each word, long holds to back up the block
   initial begin : result_sink
      int stall;
      int taken;
      stall = 0;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
               taken++;
               if (taken == 40 || taken == 160 || taken == 400) begin
                  stall = 300;
               end else begin
                  stall = calm ? 0 : $urandom_range(0, 13);
               end
            end
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               stall--;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_word(input logic [BYTE_W-1:0] b, input logic fs);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.rx_byte     <= b;
      req_ch.frame_start <= fs;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent++;
   endtask

   task automatic send_frame(input logic [WORD_W-1:0] raw, input bit mark,
                             input bit corrupt, input int len);
      logic [BYTE_W-1:0] c;
      c = crc8_step(crc8_step(CRC_INIT, raw[15:8]), raw[7:0]);
      if (corrupt) begin
         c = c ^ 8'($urandom_range(1, 255));
      end
      send_word(raw[15:8], mark);
      if (len > 1) send_word(raw[7:0], 1'b0);
      if (len > 2) send_word(c, 1'b0);
      for (int i = 3; i < len; i++) begin
         send_word(8'($urandom_range(0, 255)), 1'b0);
      end
      aligned = (len == FRAME_LEN) && (mark || aligned);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input bit en, input logic [WORD_W-1:0] off,
                             input logic [WORD_W-1:0] sc);
      settle();
      write_reg(CSR_ENABLED, CSR_DATA_W'(en));
      write_reg(CSR_OFFSET, off);
      write_reg(CSR_SCALE, sc);
      csr_we <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_scale();
      case ($urandom_range(0, 11))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hFFFF;
         3: return 16'h7FFF;
         4: return 16'h8000;
         5: return 16'($urandom_range(1, 16));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int frames;
      int kind;
      int n;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.rx_byte     <= '0;
      req_ch.frame_start <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_ENABLED;
      csr_wdata          <= '0;
      calm    = 1'b0;
      aligned = 1'b0;
      sent    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: bytes tracked, no word out
      send_frame(16'h1234, 1'b1, 1'b0, 3);
      // largest and smallest flow
      set_config(1'b1, 16'h8000, 16'h0001);
      send_frame(16'h7FFF, 1'b1, 1'b0, 3);
      set_config(1'b1, 16'h7FFF, 16'h0001);
      send_frame(16'h8000, 1'b1, 1'b0, 3);
      // most negative scale
      set_config(1'b1, 16'h0000, 16'h8000);
      send_frame(16'h8000, 1'b1, 1'b0, 3);
      // zero scale alone, then with a bad crc too
      set_config(1'b1, 16'h0000, 16'h0000);
      send_frame(16'h0100, 1'b1, 1'b0, 3);
      send_frame(16'hABCD, 1'b1, 1'b1, 3);
      // restart mark in the middle of a frame
      set_config(1'b1, 16'hFFFF, 16'h7FFF);
      send_word(8'h55, 1'b1);
      send_word(8'hAA, 1'b0);
      send_frame(16'hFFFF, 1'b1, 1'b0, 3);

      while (sent < ITEM_TARGET) begin
         set_config($urandom_range(0, 7) != 0, pick_word(), pick_scale());
         calm   = $urandom_range(0, 3) == 0;
         frames = $urandom_range(5, 30);
         repeat (frames) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               send_frame(pick_word(), !aligned || $urandom_range(0, 2) != 0,
                          $urandom_range(0, 7) == 0, FRAME_LEN);
            end else if (kind < 9) begin
               send_frame(pick_word(), 1'b1, $urandom_range(0, 3) == 0,
                          $urandom_range(1, FRAME_LEN - 1));
            end else begin
               n = $urandom_range(1, 12);
               repeat (n) begin
                  send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
               end
               aligned = 1'b0;
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
